// ----- sv/vcah_pkg.sv -----
// ----------------------------------------------------------------------------
// vcah_pkg: shared types and constants of the valve command link
// Byte codes, valve state codes, queue sizing and the request formats
// passed between the front, the queue and the back.
// ----------------------------------------------------------------------------
package vcah_pkg;

  // node role: 1 = vent node, 0 = other node
  localparam logic VENT_NODE = 1'b1;

  // valve state codes
  typedef enum logic [1:0] {
    ST_NOTHING = 2'd0,
    ST_OPEN    = 2'd1,
    ST_CLOSED  = 2'd2
  } valve_st_t;

  // link bytes
  localparam logic [7:0] BYTE_VENT_OPEN  = 8'h7B; // '{'
  localparam logic [7:0] BYTE_VENT_CLOSE = 8'h7D; // '}'
  localparam logic [7:0] BYTE_ALT_OPEN   = 8'h5B; // '['
  localparam logic [7:0] BYTE_ALT_CLOSE  = 8'h5D; // ']'
  localparam logic [7:0] BYTE_ACK        = 8'h3A; // ':'
  localparam logic [7:0] BYTE_NACK       = 8'h3B; // ';'

  localparam logic [7:0] OPEN_BYTE  = VENT_NODE ? BYTE_VENT_OPEN  : BYTE_ALT_OPEN;
  localparam logic [7:0] CLOSE_BYTE = VENT_NODE ? BYTE_VENT_CLOSE : BYTE_ALT_CLOSE;

  localparam valve_st_t RESET_STATE = VENT_NODE ? ST_OPEN : ST_NOTHING;

  // configuration
  localparam logic [15:0] ACK_INTERVAL_RESET = 16'd500;
  localparam int          CFG_AW             = 3;
  localparam logic        REG_ACK_INTERVAL   = 1'b0;

  // front to back queue
  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // one classified request for the back
  typedef struct packed {
    logic       send;     // emit ack request (two results)
    logic [7:0] cmd;      // command byte of the ack request
    valve_st_t  applied;  // applied state after the request
  } job_t;

  // one result on the output side
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       last;
    logic       drive_open;
    logic       drive_close;
    valve_st_t  valve_state;
  } res_t;

endpackage

// ----- sv/valve_command_ack_handshake.sv -----
// ----------------------------------------------------------------------------
// valve_command_ack_handshake: slave side of the valve command link
// Accepts received bytes and millisecond ticks, drives the valve and
// produces ack request bytes.
// ----------------------------------------------------------------------------
// One request is accepted per clock while full is low; its decode and state
// update finish in that cycle and a job goes into a four-entry queue. The
// output register delivers one result per cycle while pop is high: one for a
// plain request, two (ack header, then command byte) when an ack request goes
// out, so the sustained rate is then one request per cycle when none sends.
// With the queue and the output stage empty, the first result of a request
// is written to the queue and then to the output register before it is on
// the result ports. ack_interval sits at byte address 0 of the APB port.
module valve_command_ack_handshake (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic                         in_action,
  input  logic [7:0]                   in_rx_byte,
  output logic                         empty,
  input  logic                         pop,
  output logic [7:0]                   out_tx_byte,
  output logic                         out_tx_valid,
  output logic                         out_last,
  output logic                         out_drive_open,
  output logic                         out_drive_close,
  output logic [1:0]                   out_valve_state,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vcah_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import vcah_pkg::*;

  logic [15:0] ack_interval_r;
  logic        accept;
  logic        cfg_wr;
  job_t        front_job;
  job_t        q_job;
  logic        q_empty;
  logic        q_rd;
  res_t        res;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_ACK_INTERVAL) ? {16'd0, ack_interval_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_interval_r <= ACK_INTERVAL_RESET;
    end else if (cfg_wr && paddr[2] == REG_ACK_INTERVAL) begin
      ack_interval_r <= pwdata[15:0];
    end
  end

  assign accept = push && !full;

  vcah_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .action       (in_action),
    .rx_byte      (in_rx_byte),
    .ack_interval (ack_interval_r),
    .job          (front_job)
  );

  vcah_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_job  (front_job),
    .q_full  (full),
    .rd_en   (q_rd),
    .rd_job  (q_job),
    .q_empty (q_empty)
  );

  vcah_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_job   (q_job),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  // result ports
  assign out_tx_byte     = res.tx_byte;
  assign out_tx_valid    = res.tx_valid;
  assign out_last        = res.last;
  assign out_drive_open  = res.drive_open;
  assign out_drive_close = res.drive_close;
  assign out_valve_state = res.valve_state;

  // both bridge wires never driven together
  a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !(out_drive_open && out_drive_close))
    else $error("both drive wires high");

  // ack header is always followed by its command byte
  a_ack_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && out_tx_valid && !out_last) |=> (!empty && out_tx_valid && out_last))
    else $error("ack header not followed by command byte");

  // a full queue means the output stage holds a job
  a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !empty)
    else $error("queue full with idle output stage");

  // header byte carries the ack code
  a_header_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_tx_valid && !out_last) |-> (out_tx_byte == BYTE_ACK))
    else $error("bad ack header byte");

endmodule

// ----- sv/vcah_front.sv -----
// ----------------------------------------------------------------------------
// vcah_front: request intake and command decode
// Tracks requested/applied valve state, the ack handshake and the tick
// counter; classifies each request into a job for the back.
// ----------------------------------------------------------------------------
module vcah_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               action,
  input  logic [7:0]         rx_byte,
  input  logic [15:0]        ack_interval,
  output vcah_pkg::job_t     job
);
  import vcah_pkg::*;

  logic      ack_waiting_r, ack_waiting_nxt;
  valve_st_t applied_r, applied_nxt;
  valve_st_t requested_r, requested_nxt;
  logic [15:0] ticks_r, ticks_nxt;

  // next state and classification of the current request
  always_comb begin
    logic      aw;
    valve_st_t ap;
    valve_st_t rq;
    logic [15:0] tk;
    valve_st_t want;
    logic      is_cmd;
    logic      send;
    logic [7:0] cmd;
    aw     = ack_waiting_r;
    ap     = applied_r;
    rq     = requested_r;
    tk     = ticks_r;
    want   = ST_NOTHING;
    is_cmd = 1'b0;
    send   = 1'b0;
    cmd    = 8'd0;
    if (action) begin
      if (tk != 16'hFFFF) tk = tk + 16'd1;
    end else begin
      priority if (rx_byte == OPEN_BYTE) begin
        want   = ST_OPEN;
        is_cmd = 1'b1;
      end else if (rx_byte == CLOSE_BYTE) begin
        want   = ST_CLOSED;
        is_cmd = 1'b1;
      end else if (rx_byte == BYTE_ACK) begin
        aw = 1'b1;
      end else if (rx_byte == BYTE_NACK) begin
        aw = 1'b0;
        rq = ap;
      end
    end
    // command handling, with or without a pending ack header
    if (is_cmd) begin
      if (aw) begin
        if (rq == want) ap = want;
        else rq = ap;
        aw = 1'b0;
      end else begin
        rq = want;
      end
    end
    // ack request check
    if (rq != ap && tk >= ack_interval) begin
      if (rq == ST_OPEN) begin
        send = 1'b1;
        cmd  = OPEN_BYTE;
      end else if (rq == ST_CLOSED) begin
        send = 1'b1;
        cmd  = CLOSE_BYTE;
      end
    end
    if (send) tk = 16'd0;
    ack_waiting_nxt = aw;
    applied_nxt     = ap;
    requested_nxt   = rq;
    ticks_nxt       = tk;
    job.send        = send;
    job.cmd         = cmd;
    job.applied     = ap;
  end

  // link state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_waiting_r <= 1'b0;
      applied_r     <= RESET_STATE;
      requested_r   <= RESET_STATE;
      ticks_r       <= 16'd0;
    end else if (accept) begin
      ack_waiting_r <= ack_waiting_nxt;
      applied_r     <= applied_nxt;
      requested_r   <= requested_nxt;
      ticks_r       <= ticks_nxt;
    end
  end

endmodule

// ----- sv/vcah_queue.sv -----
// ----------------------------------------------------------------------------
// vcah_queue: job queue between front and back
// Small register queue so intake and result delivery stall independently.
// ----------------------------------------------------------------------------
module vcah_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  vcah_pkg::job_t wr_job,
  output logic           q_full,
  input  logic           rd_en,
  output vcah_pkg::job_t rd_job,
  output logic           q_empty
);
  import vcah_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]    count_r;

  assign q_full  = (count_r == QCW'(QDEPTH));
  assign q_empty = (count_r == '0);
  assign rd_job  = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_job;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= (wr_ptr_r == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (rd_en) rd_ptr_r <= (rd_ptr_r == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      unique case ({wr_en, rd_en})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- sv/vcah_back.sv -----
// ----------------------------------------------------------------------------
// vcah_back: result sequencer
// Holds one job in its output register and turns it into one result, or
// into the ack header and command byte of an ack request.
// ----------------------------------------------------------------------------
module vcah_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  vcah_pkg::job_t q_job,
  output logic           q_rd,
  input  logic           pop,
  output logic           empty,
  output vcah_pkg::res_t res
);
  import vcah_pkg::*;

  job_t cur_r;
  logic cur_valid_r;
  logic phase_r;       // 1 = second result of an ack request
  logic last_beat;
  logic load;

  assign empty     = !cur_valid_r;
  assign last_beat = !cur_r.send || phase_r;
  assign load      = !cur_valid_r || (pop && last_beat);
  assign q_rd      = load && !q_empty;

  // result fields from the held job
  always_comb begin
    res.tx_valid    = cur_r.send;
    res.last        = last_beat;
    res.tx_byte     = !cur_r.send ? 8'd0 : (phase_r ? cur_r.cmd : BYTE_ACK);
    res.drive_open  = (cur_r.applied == ST_OPEN);
    res.drive_close = (cur_r.applied == ST_CLOSED);
    res.valve_state = cur_r.applied;
  end

  // job register
  always_ff @(posedge clk) begin
    if (q_rd) cur_r <= q_job;
  end

  // beat control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else if (load) begin
      cur_valid_r <= !q_empty;
      phase_r     <= 1'b0;
    end else if (pop) begin
      phase_r     <= 1'b1;
    end
  end

endmodule

// ----- test/valve_command_ack_handshake_tb.sv -----
// ----------------------------------------------------------------------------
// valve_command_ack_handshake_tb: self-checking bench of the valve link slave
// Feeds received bytes and millisecond ticks through the push side, runs
// its own model of command, ack and nack handling next to the block, and
// checks every popped result in order. Covers several ack intervals,
// including zero and the 16-bit maximum, and several patterns of sender
// idling and receiver stalls.
// ----------------------------------------------------------------------------
module valve_command_ack_handshake_tb;
  import vcah_pkg::*;

  localparam int          CLK_HALF      = 10;
  localparam int          LINK_LATENCY  = 8;
  localparam int          MAX_REPORTED  = 10;
  localparam int          RANDOM_PHASES = 8;
  localparam int          PHASE_ITEMS   = 140;
  localparam int          LONG_TICKS    = 20;
  localparam longint      RUN_LIMIT     = 20_000_000;
  localparam logic        ACT_BYTE      = 1'b0;
  localparam logic        ACT_TICK      = 1'b1;
  localparam logic [15:0] INTERVAL_MAX  = 16'hFFFF;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } link_req_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                push       = 1'b0;
  logic                in_action  = 1'b0;
  logic [7:0]          in_rx_byte = 8'h00;
  logic                pop        = 1'b0;
  logic                psel       = 1'b0;
  logic                penable    = 1'b0;
  logic                pwrite     = 1'b0;
  logic [CFG_AW-1:0]   paddr      = '0;
  logic [31:0]         pwdata     = '0;
  logic                full;
  logic                empty;
  logic [7:0]          out_tx_byte;
  logic                out_tx_valid;
  logic                out_last;
  logic                out_drive_open;
  logic                out_drive_close;
  logic [1:0]          out_valve_state;
  logic [31:0]         prdata;
  logic                pready;

  // requests waiting for the driver, results waiting for the block
  link_req_t   pending_reqs[$];
  res_t        expected_results[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;

  // model state of the link
  logic [15:0] pred_interval;
  logic        pred_ack_seen;
  valve_st_t   pred_applied;
  valve_st_t   pred_requested;
  logic [15:0] pred_ticks;

  valve_command_ack_handshake i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_action       (in_action),
    .in_rx_byte      (in_rx_byte),
    .empty           (empty),
    .pop             (pop),
    .out_tx_byte     (out_tx_byte),
    .out_tx_valid    (out_tx_valid),
    .out_last        (out_last),
    .out_drive_open  (out_drive_open),
    .out_drive_close (out_drive_close),
    .out_valve_state (out_valve_state),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // one result as the link shows it after the current request
  function automatic res_t link_result(logic [7:0] tx, logic valid, logic fin);
    res_t r;
    r.tx_byte     = tx;
    r.tx_valid    = valid;
    r.last        = fin;
    r.drive_open  = (pred_applied == ST_OPEN);
    r.drive_close = (pred_applied == ST_CLOSED);
    r.valve_state = pred_applied;
    return r;
  endfunction

  // open or close byte: record a request, or settle a pending ack
  function automatic void take_command(valve_st_t want);
    if (pred_ack_seen) begin
      if (pred_requested == want) pred_applied = want;
      else pred_requested = pred_applied;
      pred_ack_seen = 1'b0;
    end else begin
      pred_requested = want;
    end
  endfunction

  // state update and expected results for one accepted request
  function automatic void predict_link(link_req_t req);
    logic [7:0] ack_cmd;
    ack_cmd = 8'h00;
    if (req.action == ACT_TICK) begin
      if (pred_ticks != INTERVAL_MAX) pred_ticks = pred_ticks + 16'd1;
    end else if (req.rx_byte == OPEN_BYTE) begin
      take_command(ST_OPEN);
    end else if (req.rx_byte == CLOSE_BYTE) begin
      take_command(ST_CLOSED);
    end else if (req.rx_byte == BYTE_ACK) begin
      pred_ack_seen = 1'b1;
    end else if (req.rx_byte == BYTE_NACK) begin
      pred_ack_seen  = 1'b0;
      pred_requested = pred_applied;
    end
    // ack request goes out while the request is unsettled and the interval is up
    if (pred_requested != pred_applied && pred_ticks >= pred_interval) begin
      if (pred_requested == ST_OPEN) ack_cmd = OPEN_BYTE;
      else if (pred_requested == ST_CLOSED) ack_cmd = CLOSE_BYTE;
    end
    if (ack_cmd != 8'h00) begin
      pred_ticks = '0;
      expected_results.push_back(link_result(BYTE_ACK, 1'b1, 1'b0));
      expected_results.push_back(link_result(ack_cmd, 1'b1, 1'b1));
    end else begin
      expected_results.push_back(link_result(8'h00, 1'b0, 1'b1));
    end
  endfunction

  function automatic void add_req(logic action, logic [7:0] rx);
    link_req_t req;
    req.action  = action;
    req.rx_byte = rx;
    pending_reqs.push_back(req);
  endfunction

  function automatic logic [7:0] any_command();
    return $urandom_range(1) ? OPEN_BYTE : CLOSE_BYTE;
  endfunction

  // one random burst; returns the number of requests added
  function automatic int add_random_burst();
    int          kind;
    int          n;
    logic [7:0]  cmd;
    kind = $urandom_range(99);
    n    = 0;
    if (kind < 35) begin
      // full exchange: command, some ticks, ack header, matching or not
      cmd = any_command();
      add_req(ACT_BYTE, cmd);
      n = $urandom_range(4);
      repeat (n) add_req(ACT_TICK, 8'($urandom_range(255)));
      add_req(ACT_BYTE, BYTE_ACK);
      if ($urandom_range(9) == 0) begin
        add_req(ACT_BYTE, BYTE_ACK);
        n++;
      end
      add_req(ACT_BYTE, ($urandom_range(3) != 0) ? cmd : any_command());
      n += 3;
    end else if (kind < 55) begin
      n = $urandom_range(1, 6);
      repeat (n) add_req(ACT_TICK, 8'($urandom_range(255)));
    end else if (kind < 62) begin
      add_req(ACT_BYTE, BYTE_NACK);
      n = 1;
    end else if (kind < 72) begin
      add_req(ACT_BYTE, any_command());
      n = 1;
    end else if (kind < 80) begin
      // ack header survives an unrelated byte
      add_req(ACT_BYTE, BYTE_ACK);
      add_req(ACT_BYTE, 8'($urandom_range(255)));
      add_req(ACT_BYTE, any_command());
      n = 3;
    end else begin
      add_req(ACT_BYTE, 8'($urandom_range(255)));
      n = 1;
    end
    return n;
  endfunction

  // register write over the config port, block idle
  task automatic write_ack_interval(logic [15:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CFG_AW'(4 * int'(REG_ACK_INTERVAL));
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pred_interval = value;
  endtask

  // wait until every request is in and every result is out
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || push || expected_results.size() != 0);
    repeat (LINK_LATENCY) @(posedge clk);
  endtask

  // driver: present pending requests, predict on acceptance
  always @(posedge clk) begin
    logic      next_push;
    link_req_t next_req;
    next_push        = push;
    next_req.action  = in_action;
    next_req.rx_byte = in_rx_byte;
    if (!rst_n) begin
      next_push = 1'b0;
    end else begin
      if (push && !full) begin
        predict_link(next_req);
        next_push = 1'b0;
      end
      if (!next_push && pending_reqs.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        next_req  = pending_reqs.pop_front();
        next_push = 1'b1;
      end
    end
    push       <= next_push;
    in_action  <= next_req.action;
    in_rx_byte <= next_req.rx_byte;
  end

  // monitor: check popped results against the oldest expectation
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && pop && !empty) begin
      got.tx_byte     = out_tx_byte;
      got.tx_valid    = out_tx_valid;
      got.last        = out_last;
      got.drive_open  = out_drive_open;
      got.drive_close = out_drive_close;
      got.valve_state = valve_st_t'(out_valve_state);
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("unexpected result: byte %h valid %b last %b open %b close %b state %0d",
                   got.tx_byte, got.tx_valid, got.last, got.drive_open,
                   got.drive_close, got.valve_state);
      end else begin
        want = expected_results.pop_front();
        if (got.tx_byte !== want.tx_byte || got.tx_valid !== want.tx_valid ||
            got.last !== want.last || got.drive_open !== want.drive_open ||
            got.drive_close !== want.drive_close ||
            got.valve_state !== want.valve_state) begin
          mismatches++;
          if (mismatches <= MAX_REPORTED) begin
            $display("result mismatch: exp byte %h valid %b last %b open %b close %b state %0d",
                     want.tx_byte, want.tx_valid, want.last, want.drive_open,
                     want.drive_close, want.valve_state);
            $display("                 got byte %h valid %b last %b open %b close %b state %0d",
                     got.tx_byte, got.tx_valid, got.last, got.drive_open,
                     got.drive_close, got.valve_state);
          end
        end
      end
    end
    pop <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // stimulus and end of run
  initial begin
    logic [15:0] interval_plan[RANDOM_PHASES];
    int          added;
    interval_plan  = '{16'd1, 16'd5, 16'd0, 16'd12, 16'd2, 16'd3, 16'd500, 16'd1};
    interval_plan[4] = 16'($urandom_range(2, 40));
    pred_interval  = ACK_INTERVAL_RESET;
    pred_ack_seen  = 1'b0;
    pred_applied   = RESET_STATE;
    pred_requested = RESET_STATE;
    pred_ticks     = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset interval: byte extremes, foreign and unknown bytes,
    // nack, repeated header, matching, already applied and mismatched acks
    add_req(ACT_BYTE, 8'h00);
    add_req(ACT_BYTE, 8'hFF);
    add_req(ACT_BYTE, BYTE_ALT_OPEN);
    add_req(ACT_BYTE, BYTE_ALT_CLOSE);
    add_req(ACT_TICK, 8'hFF);
    add_req(ACT_BYTE, CLOSE_BYTE);
    add_req(ACT_BYTE, BYTE_NACK);
    add_req(ACT_BYTE, CLOSE_BYTE);
    add_req(ACT_BYTE, BYTE_ACK);
    add_req(ACT_BYTE, BYTE_ACK);
    add_req(ACT_BYTE, CLOSE_BYTE);
    add_req(ACT_BYTE, BYTE_ACK);
    add_req(ACT_BYTE, CLOSE_BYTE);
    add_req(ACT_BYTE, OPEN_BYTE);
    add_req(ACT_BYTE, BYTE_ACK);
    add_req(ACT_BYTE, CLOSE_BYTE);
    add_req(ACT_BYTE, BYTE_ACK);
    add_req(ACT_BYTE, 8'h41);
    add_req(ACT_BYTE, OPEN_BYTE);
    wait_drained();

    // zero interval: ack request on every item while unsettled
    write_ack_interval(16'd0);
    add_req(ACT_BYTE, OPEN_BYTE);
    add_req(ACT_TICK, 8'h00);
    add_req(ACT_BYTE, 8'h00);
    add_req(ACT_BYTE, BYTE_ACK);
    add_req(ACT_BYTE, OPEN_BYTE);
    wait_drained();

    // maximum interval: ticks stay below it, so no ack request goes out
    write_ack_interval(INTERVAL_MAX);
    repeat (LONG_TICKS) add_req(ACT_TICK, 8'h00);
    add_req(ACT_BYTE, CLOSE_BYTE);
    add_req(ACT_BYTE, BYTE_ACK);
    add_req(ACT_BYTE, CLOSE_BYTE);
    wait_drained();

    // random phases over intervals and idle patterns
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      send_idle_pct  = (p % 4 == 1) ? 45 : (p % 4 == 3) ? 17 : 0;
      recv_stall_pct = (p % 4 == 2) ? 45 : (p % 4 == 3) ? 17 : 0;
      write_ack_interval(interval_plan[p]);
      added = 0;
      while (added < PHASE_ITEMS) added += add_random_burst();
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("PASS valve_command_ack_handshake");
    end else begin
      $display("FAIL valve_command_ack_handshake");
    end
    $finish;
  end

  // watchdog
  initial begin
    #RUN_LIMIT;
    $display("FAIL valve_command_ack_handshake");
    $finish;
  end

endmodule
